FILE: rtl/core/chunked_body_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the chunked body decoder checks.
// ---------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cbd_pkg.sv
// ---------------------------------------------------------------------------
// cbd_pkg
// Types, character codes and helper functions of the chunked body decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [1:0] SKIP_BYTES = 2'd2;

   typedef enum logic [7:0] {
      PH_LEAD   = 8'b0000_0001,
      PH_DIGITS = 8'b0000_0010,
      PH_IGNORE = 8'b0000_0100,
      PH_OVF    = 8'b0000_1000,
      PH_DATA   = 8'b0001_0000,
      PH_SKIP   = 8'b0010_0000,
      PH_DONE   = 8'b0100_0000,
      PH_FAIL   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       saw_digit;
      logic       pending_cr;
      logic [1:0] skip_count;
   } ctrl_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       body_valid;
      logic       finished;
      logic       failed;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         // Letters A..F and a..f have 1..6 in the low nibble.
         h.value = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// chunked_body_decoder
// Chunked transfer-coding body decoder, one body byte per request.
// ---------------------------------------------------------------------------
// Feed the body bytes that follow the header block on the req_ channel. Each
// accepted request yields exactly one response on the rsp_ channel, in order:
// the payload byte with rsp_body_valid set, or a zero byte with it clear for
// size-line and chunk-delimiter bytes. rsp_finished rises once the zero-size
// line has ended and rsp_failed once a size line without digits or with an
// overflowing size has ended; both are sticky and later bytes are ignored.
// Throughput is one request per cycle while req_stall is low; the per-byte
// state update and size shift-add sit between the state registers and the
// response register. An output register plus a one-entry skid buffer lets a
// request be taken while a response waits; req_stall rises only when both
// are full, so it is registered and does not depend combinationally on
// rsp_stall. Synchronous reset returns to the start of a size line and
// empties both response registers.
// ---------------------------------------------------------------------------
`default_nettype none

module chunked_body_decoder #(
   parameter int SIZE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_body_valid,
   output logic       rsp_finished,
   output logic       rsp_failed
);
   import cbd_pkg::*;

   ctrl_type             ctrl_ff, ctrl_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   result_type           step_result;

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic accept;
   logic pop;

   cbd_step #(
      .SIZE_BITS(SIZE_BITS)
   ) u_step (
      .cur_ctrl     (ctrl_ff),
      .cur_remaining(remaining_ff),
      .in_byte      (req_in_byte),
      .nxt_ctrl     (ctrl_in),
      .nxt_remaining(remaining_in),
      .result       (step_result)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (accept) begin
         if (out_valid_ff && !pop) begin
            // Output is held by the receiver, so park the new response.
            skid_in       = step_result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = step_result;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.phase      <= PH_LEAD;
         ctrl_ff.saw_digit  <= 1'b0;
         ctrl_ff.pending_cr <= 1'b0;
         ctrl_ff.skip_count <= 2'd0;
         remaining_ff       <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            ctrl_ff      <= ctrl_in;
            remaining_ff <= remaining_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_ff.out_byte;
   assign rsp_body_valid = out_ff.body_valid;
   assign rsp_finished   = out_ff.finished;
   assign rsp_failed     = out_ff.failed;

endmodule

`default_nettype wire

FILE: rtl/core/cbd_step.sv
// ---------------------------------------------------------------------------
// cbd_step
// Next-state and result logic for one body byte of the chunked decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module cbd_step #(
   parameter int SIZE_BITS = 32
) (
   input  cbd_pkg::ctrl_type   cur_ctrl,
   input  logic [SIZE_BITS-1:0] cur_remaining,
   input  logic [7:0]           in_byte,
   output cbd_pkg::ctrl_type   nxt_ctrl,
   output logic [SIZE_BITS-1:0] nxt_remaining,
   output cbd_pkg::result_type result
);
   import cbd_pkg::*;

   hex_type    hex;
   logic       space;
   logic       take_digit;
   logic [1:0] skip_dec;

   assign hex   = hex_digit(in_byte);
   assign space = is_space(in_byte);
   // The first non-blank byte of a line is handled as a digit-phase byte.
   assign take_digit = (cur_ctrl.phase == PH_DIGITS) ||
                       ((cur_ctrl.phase == PH_LEAD) && !space);
   assign skip_dec = (cur_ctrl.skip_count != 2'd0) ? cur_ctrl.skip_count - 2'd1 : 2'd0;

   always_comb begin
      nxt_ctrl          = cur_ctrl;
      nxt_remaining     = cur_remaining;
      result.out_byte   = 8'd0;
      result.body_valid = 1'b0;
      unique case (cur_ctrl.phase)
         PH_LEAD, PH_DIGITS, PH_IGNORE, PH_OVF: begin
            if (cur_ctrl.pending_cr && in_byte == CHAR_LF) begin
               priority if (cur_ctrl.phase == PH_OVF || !cur_ctrl.saw_digit) begin
                  nxt_ctrl.phase = PH_FAIL;
               end else if (cur_remaining == '0) begin
                  nxt_ctrl.phase = PH_DONE;
               end else begin
                  nxt_ctrl.phase = PH_DATA;
               end
               nxt_ctrl.pending_cr = 1'b0;
            end else begin
               nxt_ctrl.pending_cr = (in_byte == CHAR_CR);
               if (take_digit) begin
                  priority if (!hex.valid) begin
                     nxt_ctrl.phase = PH_IGNORE;
                  end else if (cur_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
                     nxt_ctrl.phase = PH_OVF;
                  end else begin
                     nxt_remaining      = {cur_remaining[SIZE_BITS-5:0], hex.value};
                     nxt_ctrl.saw_digit = 1'b1;
                     nxt_ctrl.phase     = PH_DIGITS;
                  end
               end
            end
         end
         PH_DATA: begin
            result.out_byte   = in_byte;
            result.body_valid = 1'b1;
            nxt_remaining     = cur_remaining - SIZE_BITS'(1);
            if (cur_remaining == SIZE_BITS'(1)) begin
               nxt_ctrl.phase      = PH_SKIP;
               nxt_ctrl.skip_count = SKIP_BYTES;
            end
         end
         PH_SKIP: begin
            if (skip_dec == 2'd0) begin
               nxt_ctrl.phase      = PH_LEAD;
               nxt_ctrl.saw_digit  = 1'b0;
               nxt_ctrl.pending_cr = 1'b0;
               nxt_ctrl.skip_count = 2'd0;
               nxt_remaining       = '0;
            end else begin
               nxt_ctrl.skip_count = skip_dec;
            end
         end
         PH_DONE, PH_FAIL: begin
         end
         default: begin
         end
      endcase
      result.finished = (nxt_ctrl.phase == PH_DONE);
      result.failed   = (nxt_ctrl.phase == PH_FAIL);
   end

endmodule

`default_nettype wire

FILE: rtl/core/cbd_checker.sv
// ---------------------------------------------------------------------------
// cbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "chunked_body_decoder_macros.svh"

module cbd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_in_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_body_valid,
   input wire logic       rsp_finished,
   input wire logic       rsp_failed
);

   // A held response keeps its contents until it is taken.
   `CBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_body_valid) && $stable(rsp_finished) && $stable(rsp_failed), "held response changed")

   // The decoder cannot be both finished and failed.
   `CBD_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_finished && rsp_failed), "finished and failed together")

   // A payload byte is only passed while the body is still open.
   `CBD_ASSERT_SAME(a_body_open, clock, reset, rsp_valid && rsp_body_valid, !rsp_finished && !rsp_failed, "payload after end of body")

   // Bytes that are not payload come out as zero.
   `CBD_ASSERT_SAME(a_zero_fill, clock, reset, rsp_valid && !rsp_body_valid, rsp_out_byte == 8'd0, "non-payload byte not zero")

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (.*);

`default_nettype wire
